// ===== src/sfpa_pkg.sv =====
package sfpa_pkg;

  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned SENSOR_W            = 16;
  localparam int unsigned ACT_W               = 4;
  localparam int unsigned OUT_SENSORS         = 10;
  localparam int unsigned SENSOR_IDX_W        = $clog2(OUT_SENSORS);
  localparam int unsigned DEFAULT_NUM_SENSORS = 10;

  // output word: ten sensors, active count, average, padded to whole bytes
  localparam int unsigned OUT_BITS    = OUT_SENSORS * SENSOR_W + ACT_W + SENSOR_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h7E;
  localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'hE7;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 1'b1;

  // sequencer strobes into the shared datapath
  typedef struct packed {
    logic clear;     // start of a new frame computation
    logic acc_lo;    // latch low byte of a sensor
    logic acc_hi;    // high byte present, accumulate the sensor
    logic div_load;  // load dividend and clear remainder
    logic div_step;  // one restoring division step
  } dp_ctrl_t;

endpackage

// ===== src/sfpa_frame_mem.sv =====
module sfpa_frame_mem #(
  parameter int unsigned DEPTH  = 2 * sfpa_pkg::DEFAULT_NUM_SENSORS,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [sfpa_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [sfpa_pkg::BYTE_W-1:0] rdata_o
);

  logic [sfpa_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [sfpa_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sfpa_datapath.sv =====
module sfpa_datapath #(
  parameter int unsigned NUM_SENSORS = sfpa_pkg::DEFAULT_NUM_SENSORS
) (
  input  logic                                                 clk_i,
  input  sfpa_pkg::dp_ctrl_t                                   ctrl_i,
  input  logic [sfpa_pkg::BYTE_W-1:0]                          rdata_i,
  output logic [sfpa_pkg::OUT_SENSORS-1:0][sfpa_pkg::SENSOR_W-1:0] sensors_o,
  output logic [sfpa_pkg::ACT_W-1:0]                           act_count_o,
  output logic [sfpa_pkg::SENSOR_W-1:0]                        avg_o
);

  localparam int unsigned CNT_W = $clog2(NUM_SENSORS + 1);
  localparam int unsigned SUM_W = sfpa_pkg::SENSOR_W + CNT_W;

  logic [sfpa_pkg::BYTE_W-1:0]   lo_q;
  logic [CNT_W-1:0]              sidx_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [SUM_W-1:0]              sum_q;
  logic [SUM_W-1:0]              quo_q;
  logic [CNT_W-1:0]              rem_q;
  logic [sfpa_pkg::OUT_SENSORS-1:0][sfpa_pkg::SENSOR_W-1:0] sensor_q;

  logic [sfpa_pkg::SENSOR_W-1:0] word;
  logic                          word_nz;
  logic [CNT_W:0]                rprime;
  logic [SUM_W-1:0]              op_a;
  logic [SUM_W-1:0]              op_b;
  logic                          op_sub;
  logic [SUM_W:0]                add_res;
  logic                          no_borrow;
  logic [CNT_W+3:0]              sidx_ext;
  logic [CNT_W+4:0]              cnt_ext;

  assign word    = {rdata_i, lo_q};
  assign word_nz = (word != '0);
  assign rprime  = {rem_q, quo_q[SUM_W-1]};

  // the one shared adder: accumulate in the sum phase, subtract divisor in the divide phase
  always_comb begin
    if (ctrl_i.div_step) begin
      op_a   = SUM_W'(rprime);
      op_b   = SUM_W'(cnt_q);
      op_sub = 1'b1;
    end else begin
      op_a   = sum_q;
      op_b   = SUM_W'(word);
      op_sub = 1'b0;
    end
  end

  assign add_res   = {1'b0, op_a} + {1'b0, op_b ^ {SUM_W{op_sub}}} + (SUM_W + 1)'(op_sub);
  assign no_borrow = add_res[SUM_W];

  assign sidx_ext = (CNT_W + 4)'(sidx_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      sum_q    <= '0;
      cnt_q    <= '0;
      sidx_q   <= '0;
      sensor_q <= '0;
    end else begin
      if (ctrl_i.acc_lo) begin
        lo_q <= rdata_i;
      end
      if (ctrl_i.acc_hi) begin
        sidx_q <= sidx_q + CNT_W'(1);
        if (word_nz) begin
          sum_q <= add_res[SUM_W-1:0];
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (sidx_ext < (CNT_W + 4)'(sfpa_pkg::OUT_SENSORS)) begin
          sensor_q[sidx_ext[sfpa_pkg::SENSOR_IDX_W-1:0]] <= word;
        end
      end
    end
  end

  // restoring divider, quotient shifts in where the dividend shifts out
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      quo_q <= sum_q;
      rem_q <= '0;
    end else if (ctrl_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], no_borrow};
      rem_q <= no_borrow ? add_res[CNT_W-1:0] : rprime[CNT_W-1:0];
    end
  end

  assign cnt_ext     = (CNT_W + 5)'(cnt_q);
  assign act_count_o = (cnt_ext > (CNT_W + 5)'(15)) ? sfpa_pkg::ACT_W'(15)
                                                     : cnt_ext[sfpa_pkg::ACT_W-1:0];
  // no active sensor: divisor is zero, report zero
  assign avg_o       = (cnt_q == '0) ? '0 : quo_q[sfpa_pkg::SENSOR_W-1:0];
  assign sensors_o   = sensor_q;

endmodule

// ===== src/sensor_frame_parser_average_core.sv =====
// a data byte is accepted while the parser is idle; bytes may come back to back
// a closing end code is followed by a sum phase (frame buffer read port) and a divide
// phase (one shared adder), then the word
// the input is not ready during that sequence; a pending output word delays its start
// reset: asynchronous active low, clears byte count, sequencer, output valid, codes to 0x7E/0xE7
// the frame buffer holds no reset value and needs no clearing pass
module sensor_frame_parser_average_core #(
  parameter int unsigned NUM_SENSORS = sfpa_pkg::DEFAULT_NUM_SENSORS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sfpa_pkg::BYTE_W-1:0]      s_axis_tdata,   // data_byte
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // sensor_0 .. sensor_9, active_count, average_level, zero pad
  output logic [sfpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [sfpa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfpa_pkg::BYTE_W-1:0]      cfg_wdata_i
);

  localparam int unsigned FRAME_LEN = 2 * NUM_SENSORS;
  localparam int unsigned ADDR_W    = $clog2(FRAME_LEN);
  localparam int unsigned BCNT_W    = $clog2(FRAME_LEN + 1);
  localparam int unsigned SUM_W     = sfpa_pkg::SENSOR_W + $clog2(NUM_SENSORS + 1);
  localparam int unsigned STEP_MAX  = (FRAME_LEN > SUM_W) ? FRAME_LEN : SUM_W;
  localparam int unsigned STEP_W    = $clog2(STEP_MAX + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // taking bytes
    ST_WAIT = 4'b0010,  // frame closed, previous word not yet taken
    ST_ACC  = 4'b0100,  // read buffer, gather sensors and sum
    ST_DIV  = 4'b1000   // average by restoring division
  } state_e;

  state_e                      state_q, state_d;
  logic [STEP_W-1:0]           step_q, step_d;
  logic [BCNT_W-1:0]           bcnt_q, bcnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [sfpa_pkg::BYTE_W-1:0] start_code_q;
  logic [sfpa_pkg::BYTE_W-1:0] end_code_q;

  logic                        in_fire;
  logic                        is_end;
  logic                        full;
  logic                        close_frame;
  logic                        drop_byte;
  logic                        mem_we;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [sfpa_pkg::BYTE_W-1:0] mem_rdata;
  sfpa_pkg::dp_ctrl_t          ctrl;

  logic [sfpa_pkg::OUT_SENSORS-1:0][sfpa_pkg::SENSOR_W-1:0] sensors;
  logic [sfpa_pkg::ACT_W-1:0]    act_count;
  logic [sfpa_pkg::SENSOR_W-1:0] avg_level;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= sfpa_pkg::START_CODE_RST;
      end_code_q   <= sfpa_pkg::END_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfpa_pkg::CFG_START_CODE: start_code_q <= cfg_wdata_i;
        sfpa_pkg::CFG_END_CODE:   end_code_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // byte classification; end code rule wins when both codes match
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign is_end        = (s_axis_tdata == end_code_q);
  assign full          = (bcnt_q == BCNT_W'(FRAME_LEN));
  assign close_frame   = is_end & full;
  assign drop_byte     = !is_end & (s_axis_tdata == start_code_q) & (bcnt_q == '0);
  // bytes past a full buffer are discarded
  assign mem_we        = in_fire & !close_frame & !drop_byte & !full;

  always_comb begin
    bcnt_d = bcnt_q;
    if (in_fire && close_frame) begin
      bcnt_d = '0;
    end else if (mem_we) begin
      bcnt_d = bcnt_q + BCNT_W'(1);
    end
  end

  // sequencer around the shared datapath
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    ctrl        = '0;
    mem_re      = 1'b0;
    mem_raddr   = step_q[ADDR_W-1:0];

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && close_frame) begin
          step_d = '0;
          if (out_valid_q) begin
            state_d = ST_WAIT;
          end else begin
            state_d    = ST_ACC;
            ctrl.clear = 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (!out_valid_q) begin
          state_d    = ST_ACC;
          ctrl.clear = 1'b1;
          step_d     = '0;
        end
      end
      ST_ACC: begin
        // read byte at step, its data is seen at the next step
        mem_re      = (step_q < STEP_W'(FRAME_LEN));
        ctrl.acc_lo = step_q[0];
        ctrl.acc_hi = !step_q[0] && (step_q != '0);
        if (step_q == STEP_W'(FRAME_LEN)) begin
          state_d = ST_DIV;
          step_d  = '0;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DIV: begin
        ctrl.div_load = (step_q == '0);
        ctrl.div_step = (step_q != '0);
        if (step_q == STEP_W'(SUM_W)) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      bcnt_q      <= bcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  sfpa_frame_mem #(
    .DEPTH  (FRAME_LEN),
    .ADDR_W (ADDR_W)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (bcnt_q[ADDR_W-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // datapath registers double as the output word; they only change while no word is pending
  sfpa_datapath #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_datapath (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .rdata_i     (mem_rdata),
    .sensors_o   (sensors),
    .act_count_o (act_count),
    .avg_o       (avg_level)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = sfpa_pkg::OUT_TDATA_W'({avg_level, act_count, sensors});

`ifndef SYNTHESIS
  // a word appears only at the end of the divide phase
  a_valid_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DIV))
    else $error("output word raised outside divide phase");

  // the computation never runs over a word still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC || state_q == ST_DIV) |-> !out_valid_q)
    else $error("datapath busy while output word pending");

  // byte count saturates at the frame length
  a_bcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= BCNT_W'(FRAME_LEN))
    else $error("byte count beyond frame length");

  // closing a frame empties the buffer and starts the sequence
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && close_frame) |=> (bcnt_q == '0) && (state_q != ST_IDLE))
    else $error("frame close did not restart parser");
`endif

endmodule
